/* hw/rtl/tre_pkg.sv */
// shared types and constants for the tag record escaper
package tre_pkg;

	localparam int LEN_BYTES = 4;
	localparam int PHASE_W   = 3;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = 2;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_BSL  = 8'h5c;
	localparam logic [7:0] CH_N    = 8'h6e;
	localparam logic [7:0] CH_R    = 8'h72;

	localparam logic MODE_TAB = 1'b0;
	localparam logic MODE_BSL = 1'b1;

	// one classified request: optional payload byte, optional second byte, optional close
	typedef struct packed {
		logic       pay;
		logic       two;
		logic       close;
		logic [7:0] b0;
		logic [7:0] b1;
	} tre_cmd_t;

endpackage

/* hw/rtl/tre_front.sv */
// front end: length assembly, payload counting and escape classification
module tre_front import tre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output tre_cmd_t   cmd
);

	logic [PHASE_W-1:0] phase_q;
	logic [31:0]        len_q;
	logic [31:0]        left_q;
	logic               mode_q;

	logic               accept;
	logic               in_len;
	logic [31:0]        acc;
	logic [31:0]        left_n;
	logic               len_done;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign in_len   = phase_q < PHASE_W'(LEN_BYTES);
	assign acc      = (phase_q == '0) ? {24'd0, in_byte}
	                : (len_q | ({24'd0, in_byte} << {phase_q[1:0], 3'b000}));
	assign len_done = phase_q == PHASE_W'(LEN_BYTES - 1);
	assign left_n   = left_q - 32'd1;

	always_comb begin
		cmd = '0;
		cmd.b0 = in_byte;
		cmd.b1 = CH_TAB;
		if (in_len) begin
			cmd.close = len_done && (acc == 32'd0);
		end else begin
			cmd.pay   = 1'b1;
			cmd.close = left_n == 32'd0;
			if (mode_q == MODE_TAB) begin
				cmd.two = in_byte == CH_LF;
			end else begin
				unique case (in_byte)
					CH_NUL: begin cmd.two = 1'b1; cmd.b0 = CH_BSL; cmd.b1 = CH_ZERO; end
					CH_LF:  begin cmd.two = 1'b1; cmd.b0 = CH_BSL; cmd.b1 = CH_N; end
					CH_CR:  begin cmd.two = 1'b1; cmd.b0 = CH_BSL; cmd.b1 = CH_R; end
					CH_BSL: begin cmd.two = 1'b1; cmd.b0 = CH_BSL; cmd.b1 = CH_BSL; end
					default: cmd.two = 1'b0;
				endcase
			end
		end
	end

	assign push = accept && (cmd.pay || cmd.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			len_q   <= '0;
			left_q  <= '0;
			mode_q  <= MODE_TAB;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_len) begin
					len_q <= acc;
					if (!len_done) begin
						phase_q <= phase_q + PHASE_W'(1);
					end else if (acc == 32'd0) begin
						phase_q <= '0;
						len_q   <= '0;
					end else begin
						left_q  <= acc;
						phase_q <= PHASE_W'(LEN_BYTES);
					end
				end else begin
					left_q <= left_n;
					if (left_n == 32'd0) begin
						phase_q <= '0;
						len_q   <= '0;
					end
				end
			end
		end
	end

endmodule

/* hw/rtl/tre_fifo.sv */
// short request queue between front and back
module tre_fifo import tre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tre_cmd_t wr_cmd,
	input  logic     pop,
	output tre_cmd_t rd_cmd,
	output logic     full,
	output logic     empty
);

	tre_cmd_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign full   = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty  = count_q == '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

/* hw/rtl/tre_back.sv */
// back end: expands each queued request into output bytes, one per cycle while out_ready is high
module tre_back import tre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tre_cmd_t   cmd,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_end,
	output logic       out_last
);

	logic [1:0] idx_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       oe_q;
	logic       ol_q;

	logic       load;
	logic [1:0] n_res;
	logic       is_last;
	logic       sel_close;
	logic [7:0] sel_byte;

	assign load    = (!ov_q || out_ready) && !q_empty;
	assign n_res   = {1'b0, cmd.pay} + {1'b0, cmd.two} + {1'b0, cmd.close};
	assign is_last = idx_q == (n_res - 2'd1);
	assign pop     = load && is_last;

	// result order: payload byte, second escape byte, closing newline
	always_comb begin
		sel_close = 1'b1;
		sel_byte  = CH_LF;
		case (idx_q)
			2'd0: if (cmd.pay) begin sel_close = 1'b0; sel_byte = cmd.b0; end
			2'd1: if (cmd.two) begin sel_close = 1'b0; sel_byte = cmd.b1; end
			default: sel_close = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= sel_byte;
			oe_q <= sel_close;
			ol_q <= is_last;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_end   = oe_q;
	assign out_last  = ol_q;

endmodule

/* hw/rtl/tag_record_escaper.sv */
// Escapes a byte stream of length-prefixed records (4-byte little-endian length, then the
// payload) and closes every record with a newline flagged in tuser. An input byte that
// gives results is queued as one request; a length byte that gives none is not. The output
// register sends one byte per cycle while m_axis_tready is high, so a byte that expands to
// two or three results holds the output until all are sent and sustained throughput is one
// output byte per cycle. Length bytes that produce no result are accepted while the
// four-entry queue has room; once it is full every input byte waits for the back end to free
// an entry. tlast marks the final result of each input byte.
module tag_record_escaper import tre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,      // escape_mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] record_end
	output logic       m_axis_tlast    // last_of_run
);

	tre_cmd_t push_cmd;
	tre_cmd_t head_cmd;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;

	tre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.cmd       (push_cmd)
	);

	tre_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	tre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_end   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

/* tb/tb_tag_record_escaper.sv */
// self-checking testbench for the tag record escaper with a bytewise escaping predictor
`timescale 1ns / 100ps

module tb_tag_record_escaper;
	import tre_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RST_CYCLES  = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 12;
	localparam int RX_HOLD_LEN = 400;
	localparam int RAND_ITEMS  = 380;
	localparam int HOLD_PHASE  = 2;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       rec_end;
		logic       last;
	} esc_result_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_we        = 1'b0;
	logic       cfg_wdata     = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [7:0] out_byte
	logic       m_axis_tuser;            // [0] record_end
	logic       m_axis_tlast;            // last_of_run

	// predictor state
	logic        esc_mode   = MODE_TAB;
	logic [2:0]  len_phase  = '0;
	logic [31:0] len_acc    = '0;
	logic [31:0] bytes_left = '0;

	esc_result_t escaped_q[$];
	logic [7:0]  tx_bytes_q[$];
	logic [7:0]  stream_q[$];

	int   mismatch_cnt = 0;
	int   cycle_cnt    = 0;
	int   tx_gap       = 0;
	int   rx_stall     = 0;
	int   rx_hold_left = 0;
	logic rx_hold_req  = 1'b0;
	logic rx_hold_done = 1'b0;
	logic tx_calm      = 1'b0;
	logic rx_calm      = 1'b0;

	tag_record_escaper uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// works out the escaped bytes one accepted stream byte gives
	function automatic void escape_byte(input logic [7:0] b);
		esc_result_t outs[$];
		logic [31:0] acc;
		if (len_phase < LEN_BYTES) begin
			acc = (len_phase == 0) ? {24'h0, b} : (len_acc | ({24'h0, b} << (8 * len_phase)));
			len_acc = acc;
			if (len_phase + 1 < LEN_BYTES) begin
				len_phase = len_phase + 3'd1;
			end else if (acc == 0) begin
				outs.push_back('{CH_LF, 1'b1, 1'b0});
				len_phase = '0;
				len_acc   = '0;
			end else begin
				bytes_left = acc;
				len_phase  = 3'(LEN_BYTES);
			end
		end else begin
			if (esc_mode == MODE_TAB) begin
				outs.push_back('{b, 1'b0, 1'b0});
				if (b == CH_LF)
					outs.push_back('{CH_TAB, 1'b0, 1'b0});
			end else begin
				case (b)
					CH_NUL: begin
						outs.push_back('{CH_BSL, 1'b0, 1'b0});
						outs.push_back('{CH_ZERO, 1'b0, 1'b0});
					end
					CH_LF: begin
						outs.push_back('{CH_BSL, 1'b0, 1'b0});
						outs.push_back('{CH_N, 1'b0, 1'b0});
					end
					CH_CR: begin
						outs.push_back('{CH_BSL, 1'b0, 1'b0});
						outs.push_back('{CH_R, 1'b0, 1'b0});
					end
					CH_BSL: begin
						outs.push_back('{CH_BSL, 1'b0, 1'b0});
						outs.push_back('{CH_BSL, 1'b0, 1'b0});
					end
					default: outs.push_back('{b, 1'b0, 1'b0});
				endcase
			end
			bytes_left = bytes_left - 32'd1;
			if (bytes_left == 0) begin
				outs.push_back('{CH_LF, 1'b1, 1'b0});
				len_phase = '0;
				len_acc   = '0;
			end
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			escaped_q.push_back(outs[i]);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		int gap_n;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			tx_gap        <= 0;
		end else begin
			gap_n = tx_gap;
			if (s_axis_tvalid && s_axis_tready) begin
				escape_byte(s_axis_tdata);
				tx_bytes_q.delete(0);
				gap_n = tx_calm ? 0 : pick_gap();
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// request still pending, hold it
			end else if (gap_n > 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap        <= gap_n - 1;
			end else if (tx_bytes_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= tx_bytes_q[0];
				tx_gap        <= 0;
			end else begin
				s_axis_tvalid <= 1'b0;
				tx_gap        <= 0;
			end
		end
	end

	task automatic report_mismatch(input esc_result_t want, input logic have_want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			if (have_want)
				$display("mismatch: expected data %02h end %0b last %0b, got data %02h end %0b last %0b",
					want.data, want.rec_end, want.last, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			else
				$display("mismatch: nothing expected, got data %02h end %0b last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	endtask

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		esc_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall      <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (escaped_q.size() == 0) begin
					report_mismatch('0, 1'b0);
				end else begin
					want = escaped_q.pop_front();
					if (m_axis_tdata !== want.data || m_axis_tuser !== want.rec_end ||
					    m_axis_tlast !== want.last)
						report_mismatch(want, 1'b1);
				end
			end
			if (rx_stall > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall      <= rx_stall - 1;
			end else begin
				m_axis_tready <= (rx_hold_left == 0);
				rx_stall      <= rx_calm ? 0 : pick_gap();
			end
		end
	end

	// one long receiver hold-off so the block fills and back-pressures its input
	always @(posedge clk) begin
		if (rx_hold_req && !rx_hold_done) begin
			rx_hold_left <= RX_HOLD_LEN;
			rx_hold_done <= 1'b1;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		esc_mode   = m;
	endtask

	task automatic drain();
		while (tx_bytes_q.size() != 0 || s_axis_tvalid || escaped_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_len(input logic [31:0] len);
		for (int i = 0; i < LEN_BYTES; i++)
			tx_bytes_q.push_back(len[8 * i +: 8]);
	endtask

	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)  return CH_NUL;
		if (r < 18) return CH_LF;
		if (r < 24) return CH_CR;
		if (r < 32) return CH_BSL;
		if (r < 35) return CH_TAB;
		return 8'($urandom_range(0, 255));
	endfunction

	// appends one whole record to the random byte stream
	function automatic void append_record();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = 0;
		else if (r < 70)
			len = $urandom_range(1, 6);
		else if (r < 94)
			len = $urandom_range(7, 40);
		else
			len = $urandom_range(256, 300);
		for (int i = 0; i < LEN_BYTES; i++)
			stream_q.push_back(8'(len >> (8 * i)));
		for (int i = 0; i < len; i++)
			stream_q.push_back(pick_payload());
	endfunction

	initial begin
		int fed;
		int chunk;
		int phase_no;
		logic [7:0] dir_tab[] = '{CH_LF, CH_NUL, CH_BSL, 8'hff};
		logic [7:0] dir_bsl[] = '{CH_NUL, CH_LF, CH_CR, CH_BSL};

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty record, tab mode specials, backslash mode specials,
		// then a mode switch in the middle of a record
		write_mode(MODE_TAB);
		push_len(32'd0);
		push_len(32'd4);
		foreach (dir_tab[i])
			tx_bytes_q.push_back(dir_tab[i]);
		drain();
		write_mode(MODE_BSL);
		push_len(32'd4);
		foreach (dir_bsl[i])
			tx_bytes_q.push_back(dir_bsl[i]);
		push_len(32'd2);
		tx_bytes_q.push_back(CH_LF);
		drain();
		write_mode(MODE_TAB);
		tx_bytes_q.push_back(CH_LF);
		drain();

		// random phases; phase boundaries fall anywhere in a record, and the bytes
		// still queued for the open record count towards the budget
		fed = 0;
		phase_no = 0;
		while (phase_no <= HOLD_PHASE || fed + stream_q.size() < RAND_ITEMS) begin
			write_mode(phase_no[0] ? MODE_BSL : MODE_TAB);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			chunk   = $urandom_range(20, 70);
			if (phase_no == HOLD_PHASE) begin
				tx_calm     = 1'b1;
				chunk       = 60;
				rx_hold_req = 1'b1;
			end
			while (stream_q.size() < chunk)
				append_record();
			for (int i = 0; i < chunk; i++)
				tx_bytes_q.push_back(stream_q.pop_front());
			fed += chunk;
			phase_no++;
			drain();
		end

		// finish the open record, then leave one with the largest length unfinished
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		while (stream_q.size() != 0)
			tx_bytes_q.push_back(stream_q.pop_front());
		push_len(32'hffff_ffff);
		for (int i = 0; i < 20; i++)
			tx_bytes_q.push_back(pick_payload());
		drain();

		if (mismatch_cnt == 0 && escaped_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tre_pkg.sv
hw/rtl/tre_front.sv
hw/rtl/tre_fifo.sv
hw/rtl/tre_back.sv
hw/rtl/tag_record_escaper.sv
tb/tb_tag_record_escaper.sv
